// ===== src/brce_pkg.sv =====
// ----------------------------------------------------------------------------
// brce_pkg
// shared types and constants for the bitmap run claim engine
// ----------------------------------------------------------------------------
package brce_pkg;

	// fixed width of every field on the result beats and of position and run_length on item beats
	localparam int FIELD_W = 13;

	// default geometry, handed to the top level parameters
	localparam int NUM_GRANULES_DEF = 4096;
	localparam int WORD_BITS_DEF    = 64;

	// saturation ceiling of the free count field
	localparam int FIELD_MAX = 8191;

	typedef enum logic [1:0] {
		ACT_CLAIM_LEFT  = 2'd0,
		ACT_CLAIM_RIGHT = 2'd1,
		ACT_MARK_FREE   = 2'd2,
		ACT_MARK_ALLOC  = 2'd3
	} action_t;

	typedef struct packed {
		action_t              action;
		logic [FIELD_W-1:0]   position;
		logic [FIELD_W-1:0]   run_length;
	} item_t;

	typedef struct packed {
		logic [FIELD_W-1:0]   claimed_count;
		logic [FIELD_W-1:0]   run_edge;
		logic [FIELD_W-1:0]   free_count;
	} result_t;

	// control of the shared word unit
	typedef struct packed {
		logic reverse;   // walk the word from the top bit down
		logic claim;     // take the run of ones from the start offset
		logic set_bits;  // set the masked bits instead of clearing them
	} unit_ctl_t;

endpackage

// ===== src/brce_stream_if.sv =====
// ----------------------------------------------------------------------------
// brce_stream_if
// valid/ready channel carrying one payload beat per handshake
// ----------------------------------------------------------------------------
interface brce_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);

endinterface

// ===== src/brce_ram.sv =====
// ----------------------------------------------------------------------------
// brce_ram
// generic simple dual port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module brce_ram #(
	parameter  int WIDTH = 64,
	parameter  int DEPTH = 64,
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== src/brce_run_unit.sv =====
// ----------------------------------------------------------------------------
// brce_run_unit
// one bitmap word: find the run of free bits from an offset, or mask a
// bit range, and return the updated word
// ----------------------------------------------------------------------------
module brce_run_unit #(
	parameter  int WORD_BITS = brce_pkg::WORD_BITS_DEF,
	localparam int BW        = $clog2(WORD_BITS)
) (
	input  logic [WORD_BITS-1:0] word_in,
	input  logic [BW-1:0]        lo,
	input  logic [BW:0]          hi,
	input  brce_pkg::unit_ctl_t  ctl,
	output logic [WORD_BITS-1:0] word_out,
	output logic [BW:0]          run,
	output logic                 run_full
);

	logic [WORD_BITS-1:0] w;
	logic [WORD_BITS-1:0] sh;
	logic [WORD_BITS-1:0] mask;
	logic [WORD_BITS-1:0] nw;
	logic [BW:0]          stop;

	always_comb begin
		for (int i = 0; i < WORD_BITS; i++) begin
			w[i] = ctl.reverse ? word_in[WORD_BITS-1-i] : word_in[i];
		end
		sh = w >> lo;
		// first zero at or above the offset ends the run
		run = (BW+1)'(WORD_BITS);
		for (int i = WORD_BITS-1; i >= 0; i--) begin
			if (!sh[i]) begin
				run = (BW+1)'(i);
			end
		end
		stop = ctl.claim ? ({1'b0, lo} + run) : hi;
		for (int i = 0; i < WORD_BITS; i++) begin
			mask[i] = ((BW+1)'(i) >= {1'b0, lo}) && ((BW+1)'(i) < stop);
		end
		nw = ctl.set_bits ? (w | mask) : (w & ~mask);
		for (int i = 0; i < WORD_BITS; i++) begin
			word_out[i] = ctl.reverse ? nw[WORD_BITS-1-i] : nw[i];
		end
		run_full = ctl.claim && (stop == (BW+1)'(WORD_BITS));
	end

endmodule

// ===== src/bitmap_run_claim_engine.sv =====
// ----------------------------------------------------------------------------
// bitmap_run_claim_engine
// free-granule bitmap with contiguous claims and range marking, one
// bitmap word per cycle through a shared word unit
// ----------------------------------------------------------------------------
//
//  channel  dir  beat payload                                handshake
//  -------  ---  ------------------------------------------  ------------
//  item     in   action, position, run_length                valid/ready
//  result   out  claimed_count, run_edge, free_count         valid/ready
//
//  an item is taken in the idle step, walks the bitmap words it touches
//  and then loads its result in the finish step; the walk rests on the one
//  word read and write of the bitmap ram per cycle
//  after reset a clearing pass writes zero to every word,
//  with item.ready low
//  the next item is taken while a result beat still waits; a stalled result
//  holds the engine in its finish step until the beat is taken
//  WORD_BITS is a power of two
//
module bitmap_run_claim_engine #(
	parameter int NUM_GRANULES = brce_pkg::NUM_GRANULES_DEF,
	parameter int WORD_BITS    = brce_pkg::WORD_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	brce_stream_if.sink           item,
	brce_stream_if.source         result
);

	localparam int FW       = brce_pkg::FIELD_W;
	localparam int NW       = (NUM_GRANULES + WORD_BITS - 1) / WORD_BITS;
	localparam int AW       = (NW > 1) ? $clog2(NW) : 1;
	localparam int BW       = $clog2(WORD_BITS);
	localparam int IW0      = $clog2(NUM_GRANULES + 1);
	localparam int IW       = (IW0 > FW + 1) ? IW0 : FW + 1;
	localparam int FREE_MAX = (NUM_GRANULES < brce_pkg::FIELD_MAX) ?
		NUM_GRANULES : brce_pkg::FIELD_MAX;

	localparam logic [IW-1:0] NG_I      = IW'(NUM_GRANULES);
	localparam logic [IW:0]   FREE_MAX_I = (IW+1)'(FREE_MAX);
	localparam logic [AW-1:0] LAST_WORD = AW'(NW - 1);
	localparam logic [BW:0]   WB_I      = (BW+1)'(WORD_BITS);

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_WALK,
		ST_FINISH
	} state_t;

	state_t              state_q;
	brce_pkg::action_t   act_q;
	logic [IW-1:0]       pos_q;
	logic [IW-1:0]       n_q;         // clipped range length of a mark
	logic [IW-1:0]       claimed_q;
	logic [AW-1:0]       word_q;
	logic [AW-1:0]       last_q;      // final word of a mark range
	logic [BW-1:0]       lo_q;        // start offset inside the current word
	logic [BW:0]         hi_last_q;   // end offset inside the final mark word
	logic [AW-1:0]       clr_q;
	logic [FW-1:0]       free_q;
	logic                rsp_valid_q;
	brce_pkg::result_t   rsp_q;

	// ---------------------------------------------------------------- decode
	// work out the start word and offsets of a new item
	brce_pkg::item_t   in_d;
	logic [IW-1:0]     pos_in;
	logic [IW-1:0]     end_raw;
	logic [IW-1:0]     end_clip;
	logic [IW-1:0]     end_m1;
	logic [IW-1:0]     mark_n;
	logic [IW-1:0]     g_left;
	logic [AW-1:0]     start_word;
	logic [BW-1:0]     start_lo;
	logic              skip_walk;
	logic              accept;

	assign in_d   = item.data;
	assign pos_in = IW'(in_d.position);
	assign end_raw  = pos_in + IW'(in_d.run_length);
	assign end_clip = (end_raw > NG_I) ? NG_I : end_raw;
	assign end_m1   = end_clip - IW'(1);
	assign mark_n   = (end_clip > pos_in) ? (end_clip - pos_in) : '0;
	assign g_left   = pos_in - IW'(1);

	always_comb begin
		unique case (in_d.action)
			brce_pkg::ACT_CLAIM_LEFT: begin
				// walk downward: offsets count from the top bit of the word
				start_word = AW'(g_left >> BW);
				start_lo   = ~g_left[BW-1:0];
				skip_walk  = (pos_in == '0) || (pos_in > NG_I);
			end
			brce_pkg::ACT_CLAIM_RIGHT: begin
				start_word = AW'(pos_in >> BW);
				start_lo   = pos_in[BW-1:0];
				skip_walk  = (pos_in >= NG_I);
			end
			default: begin
				start_word = AW'(pos_in >> BW);
				start_lo   = pos_in[BW-1:0];
				skip_walk  = (end_clip <= pos_in);
			end
		endcase
	end

	assign item.ready = (state_q == ST_IDLE);
	assign accept     = item.valid && item.ready;

	// ---------------------------------------------------------- word unit
	logic                  act_left;
	logic                  act_claim;
	brce_pkg::unit_ctl_t   ctl;
	logic [WORD_BITS-1:0]  rd_word;
	logic [WORD_BITS-1:0]  wr_word;
	logic [BW:0]           run;
	logic                  run_full;
	logic [BW:0]           unit_hi;
	logic                  more;
	logic [AW-1:0]         next_word;

	assign act_left     = (act_q == brce_pkg::ACT_CLAIM_LEFT);
	assign act_claim    = (act_q == brce_pkg::ACT_CLAIM_LEFT) ||
		(act_q == brce_pkg::ACT_CLAIM_RIGHT);
	assign ctl.reverse  = act_left;
	assign ctl.claim    = act_claim;
	assign ctl.set_bits = (act_q == brce_pkg::ACT_MARK_FREE);
	assign unit_hi      = (word_q == last_q) ? hi_last_q : WB_I;

	brce_run_unit #(
		.WORD_BITS (WORD_BITS)
	) u_unit (
		.word_in  (rd_word),
		.lo       (lo_q),
		.hi       (unit_hi),
		.ctl      (ctl),
		.word_out (wr_word),
		.run      (run),
		.run_full (run_full)
	);

	// a claim moves on only when the whole rest of the word was free
	assign next_word = act_left ? (word_q - AW'(1)) : (word_q + AW'(1));
	always_comb begin
		if (act_claim) begin
			more = run_full && (act_left ? (word_q != '0) : (word_q != LAST_WORD));
		end else begin
			more = (word_q != last_q);
		end
	end

	// ---------------------------------------------------------- bitmap ram
	logic                  ram_we;
	logic [AW-1:0]         ram_waddr;
	logic [WORD_BITS-1:0]  ram_wdata;
	logic [AW-1:0]         ram_raddr;

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = word_q;
		ram_wdata = wr_word;
		ram_raddr = word_q;
		unique case (state_q)
			ST_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_q;
				ram_wdata = '0;
			end
			ST_IDLE: begin
				ram_raddr = start_word;
			end
			ST_WALK: begin
				// write back this word, fetch the neighbor in case the run goes on
				ram_we    = 1'b1;
				ram_raddr = next_word;
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	brce_ram #(
		.WIDTH (WORD_BITS),
		.DEPTH (NW)
	) u_bitmap (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (rd_word)
	);

	// ---------------------------------------------------------- finish math
	logic [IW-1:0]  amount;
	logic [IW:0]    free_sum;
	logic [FW-1:0]  free_next;
	logic [IW-1:0]  edge_calc;
	logic           load;

	assign amount   = act_claim ? claimed_q : n_q;
	assign free_sum = (IW+1)'(free_q) + (IW+1)'(n_q);

	always_comb begin
		if (act_q == brce_pkg::ACT_MARK_FREE) begin
			free_next = (free_sum > FREE_MAX_I) ? FW'(FREE_MAX) : FW'(free_sum);
		end else if (IW'(free_q) >= amount) begin
			free_next = FW'(IW'(free_q) - amount);
		end else begin
			free_next = '0;
		end
		unique case (act_q)
			brce_pkg::ACT_CLAIM_LEFT:  edge_calc = pos_q - claimed_q;
			brce_pkg::ACT_CLAIM_RIGHT: edge_calc = pos_q + claimed_q;
			default:                   edge_calc = '0;
		endcase
	end

	assign load = (state_q == ST_FINISH) && (!rsp_valid_q || result.ready);

	assign result.valid = rsp_valid_q;
	assign result.data  = rsp_q;

	// ---------------------------------------------------------- sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			act_q       <= brce_pkg::ACT_CLAIM_LEFT;
			pos_q       <= '0;
			n_q         <= '0;
			claimed_q   <= '0;
			word_q      <= '0;
			last_q      <= '0;
			lo_q        <= '0;
			hi_last_q   <= '0;
			clr_q       <= '0;
			free_q      <= '0;
			rsp_valid_q <= 1'b0;
			rsp_q       <= '0;
		end else begin
			if (load) begin
				rsp_valid_q         <= 1'b1;
				rsp_q.claimed_count <= FW'(claimed_q);
				rsp_q.run_edge      <= FW'(edge_calc);
				rsp_q.free_count    <= free_next;
				free_q              <= free_next;
			end else if (result.ready) begin
				rsp_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == LAST_WORD) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						act_q     <= in_d.action;
						pos_q     <= pos_in;
						n_q       <= mark_n;
						claimed_q <= '0;
						word_q    <= start_word;
						last_q    <= AW'(end_m1 >> BW);
						lo_q      <= start_lo;
						hi_last_q <= {1'b0, end_m1[BW-1:0]} + (BW+1)'(1);
						state_q   <= skip_walk ? ST_FINISH : ST_WALK;
					end
				end
				ST_WALK: begin
					if (act_claim) begin
						claimed_q <= claimed_q + IW'(run);
					end
					word_q <= next_word;
					lo_q   <= '0;
					if (!more) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// ---------------------------------------------------------- assertions
	a_free_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		IW'(free_q) <= IW'(FREE_MAX))
		else $error("free count above its ceiling");

	a_walk_word_in_map: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WALK) |-> ({1'b0, word_q} < (AW+1)'(NW)))
		else $error("walk left the bitmap");

	a_mark_stays_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WALK) && !act_claim |-> (word_q <= last_q))
		else $error("mark walked past its last word");

	a_one_item_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !item.ready)
		else $error("item taken while another is at work");

	a_claim_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FINISH) |-> (claimed_q <= NG_I))
		else $error("claim larger than the bitmap");

endmodule

// ===== sim/bitmap_run_claim_engine_checker.sv =====
// ----------------------------------------------------------------------------
// bitmap_run_claim_engine_checker
// watches the item and result channels, keeps a shadow free bitmap and
// compares every result beat with the outcome predicted for its item
// ----------------------------------------------------------------------------
module bitmap_run_claim_engine_checker
	import brce_pkg::*;
#(
	parameter int NUM_GRANULES = NUM_GRANULES_DEF
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    item_valid,
	input  logic    item_ready,
	input  item_t   item_beat,
	input  logic    result_valid,
	input  logic    result_ready,
	input  result_t result_beat,
	output int      bad_beats,
	output int      outcomes_owed
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int FREE_CEIL = (NUM_GRANULES < FIELD_MAX) ? NUM_GRANULES : FIELD_MAX;

	// shadow state: one bit per granule, 1 = free
	bit [NUM_GRANULES-1:0] free_map;
	int unsigned           free_total;
	result_t               queued_outcomes[$];

	function automatic void drop_free(input int unsigned n);
		free_total = (free_total >= n) ? free_total - n : 0;
	endfunction

	function automatic result_t apply_to_map(input item_t it);
		result_t     r;
		int unsigned pos, len, stop, e, n;
		r   = '0;
		pos = it.position;
		len = it.run_length;
		case (it.action)
			ACT_CLAIM_LEFT: begin
				e = pos;
				// a boundary past the map sees nothing free below it
				if (pos <= NUM_GRANULES) begin
					while (e > 0 && free_map[e-1]) begin
						free_map[e-1] = 1'b0;
						e--;
					end
				end
				r.claimed_count = FIELD_W'(pos - e);
				r.run_edge      = FIELD_W'(e);
				drop_free(pos - e);
			end
			ACT_CLAIM_RIGHT: begin
				e = pos;
				while (e < NUM_GRANULES && free_map[e]) begin
					free_map[e] = 1'b0;
					e++;
				end
				r.claimed_count = FIELD_W'(e - pos);
				r.run_edge      = FIELD_W'(e);
				drop_free(e - pos);
			end
			default: begin
				// range clipped to the map, count moves by the clipped length
				stop = pos + len;
				if (stop > NUM_GRANULES)
					stop = NUM_GRANULES;
				n = 0;
				for (int unsigned g = pos; g < stop; g++) begin
					free_map[g] = (it.action == ACT_MARK_FREE);
					n++;
				end
				if (it.action == ACT_MARK_FREE) begin
					free_total = (free_total + n > FREE_CEIL) ? FREE_CEIL : free_total + n;
				end else begin
					drop_free(n);
				end
			end
		endcase
		r.free_count = FIELD_W'(free_total);
		return r;
	endfunction

	function automatic void compare_field(input string label,
			input logic [FIELD_W-1:0] want, input logic [FIELD_W-1:0] got);
		if (got !== want) begin
			$display("%0t: %s expected %0d actual %0d", $time, label, want, got);
			bad_beats++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			free_map      = '0;
			free_total    = 0;
			queued_outcomes.delete();
			bad_beats     = 0;
			outcomes_owed = 0;
		end else begin
			// item first: a result at the same edge belongs to an older item
			if (item_valid && item_ready)
				queued_outcomes.push_back(apply_to_map(item_beat));
			if (result_valid && result_ready) begin
				if (queued_outcomes.size() == 0) begin
					$display("%0t: result beat with none owed, expected nothing actual %0d/%0d/%0d",
						$time, result_beat.claimed_count, result_beat.run_edge,
						result_beat.free_count);
					bad_beats++;
				end else begin
					want = queued_outcomes.pop_front();
					compare_field("claimed_count", want.claimed_count, result_beat.claimed_count);
					compare_field("run_edge", want.run_edge, result_beat.run_edge);
					compare_field("free_count", want.free_count, result_beat.free_count);
				end
			end
			outcomes_owed = queued_outcomes.size();
		end
	end

endmodule

// ===== sim/bitmap_run_claim_engine_test.sv =====
// ----------------------------------------------------------------------------
// bitmap_run_claim_engine_test
// drives claims and range marks into the engine with random gaps and
// back-pressure; a checker beside the block predicts and compares results
// ----------------------------------------------------------------------------
module bitmap_run_claim_engine_test;
	timeunit 1ns;
	timeprecision 1ps;

	import brce_pkg::*;

	localparam int NUM_GRANULES = NUM_GRANULES_DEF;
	localparam int RANDOM_ITEMS = 930;
	// the last stretch of items runs with no item gaps and the result side always ready
	localparam int CALM_TAIL    = 150;
	// long result hold-off so the engine backs up into the item channel
	localparam int HOLD_CYCLES  = 400;
	localparam int HOLD_AT      = 200;
	// leave room after the drain for a stray beat
	localparam int DRAIN_CYCLES = 100;

	logic        clk = 1'b0;
	logic        arst_n;
	bit          idle_on  = 1'b1;
	bit          hold_req = 1'b0;
	int          bad_beats;
	int          outcomes_owed;
	// last range marked free, claims aim at its edges to hit real runs
	int unsigned span_lo = 0;
	int unsigned span_hi = 0;

	brce_stream_if #(.payload_t(item_t))   item_ch ();
	brce_stream_if #(.payload_t(result_t)) result_ch ();

	bitmap_run_claim_engine #(
		.NUM_GRANULES(NUM_GRANULES),
		.WORD_BITS   (WORD_BITS_DEF)
	) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.item  (item_ch),
		.result(result_ch)
	);

	bitmap_run_claim_engine_checker #(
		.NUM_GRANULES(NUM_GRANULES)
	) watch (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_ch.valid),
		.item_ready   (item_ch.ready),
		.item_beat    (item_ch.data),
		.result_valid (result_ch.valid),
		.result_ready (result_ch.ready),
		.result_beat  (result_ch.data),
		.bad_beats    (bad_beats),
		.outcomes_owed(outcomes_owed)
	);

	always #5 clk = ~clk;

	function automatic item_t pack_item(input action_t act, input int unsigned pos,
			input int unsigned len);
		item_t it;
		it.action     = act;
		it.position   = FIELD_W'(pos);
		it.run_length = FIELD_W'(len);
		return it;
	endfunction

	// mostly short ranges, some long ones, a few zero or past the map
	function automatic int unsigned pick_length();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 65)
			return $urandom_range(1, 96);
		else if (r < 88)
			return $urandom_range(1, 1024);
		else if (r < 94)
			return 0;
		else if (r < 98)
			return $urandom_range(1, NUM_GRANULES);
		else
			return $urandom_range(NUM_GRANULES + 1, FIELD_MAX);
	endfunction

	// claim boundary: mostly close to an edge of the last free range
	function automatic int unsigned pick_boundary(input int unsigned base);
		int unsigned r, p;
		r = $urandom_range(0, 99);
		if (r < 85) begin
			p = base + $urandom_range(0, 8);
			p = (p < 4) ? 0 : p - 4;
			return (p > FIELD_MAX) ? FIELD_MAX : p;
		end else if (r < 95) begin
			return $urandom_range(0, NUM_GRANULES);
		end else begin
			return $urandom_range(0, FIELD_MAX);
		end
	endfunction

	// one beat on the item channel; a random gap may come first
	task automatic send_item(input item_t it);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			item_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
		item_ch.valid <= 1'b1;
		item_ch.data  <= it;
		do @(posedge clk); while (!item_ch.ready);
	endtask

	// result side: ready stretches, short stalls and one long hold-off
	initial begin
		bit held;
		held = 1'b0;
		result_ch.ready <= 1'b0;
		@(posedge clk);
		forever begin
			if (hold_req && !held) begin
				held = 1'b1;
				result_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else if (idle_on && $urandom_range(0, 3) == 0) begin
				result_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 8)) @(posedge clk);
			end else begin
				result_ch.ready <= 1'b1;
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end
		end
	end

	// item side and verdict
	initial begin
		int unsigned pick, pos, len;
		item_t       it;
		arst_n        <= 1'b0;
		item_ch.valid <= 1'b0;
		item_ch.data  <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// empty map: nothing to claim, count floors at zero
		send_item(pack_item(ACT_CLAIM_LEFT, 0, 0));
		send_item(pack_item(ACT_CLAIM_RIGHT, 0, FIELD_MAX));
		send_item(pack_item(ACT_MARK_ALLOC, 0, 10));
		send_item(pack_item(ACT_MARK_FREE, 0, 0));
		// whole map free, then an overlapping clipped mark saturates the count
		send_item(pack_item(ACT_MARK_FREE, 0, NUM_GRANULES));
		send_item(pack_item(ACT_MARK_FREE, 4000, FIELD_MAX));
		// claims running to the top and to the bottom of the map
		send_item(pack_item(ACT_CLAIM_RIGHT, 100, 0));
		send_item(pack_item(ACT_CLAIM_LEFT, 100, 0));
		send_item(pack_item(ACT_MARK_FREE, 4000, 96));
		// boundaries at and past the end of the map
		send_item(pack_item(ACT_CLAIM_LEFT, NUM_GRANULES + 1, 0));
		send_item(pack_item(ACT_CLAIM_RIGHT, NUM_GRANULES, 0));
		send_item(pack_item(ACT_CLAIM_RIGHT, FIELD_MAX, 0));
		send_item(pack_item(ACT_CLAIM_LEFT, NUM_GRANULES, 0));
		// word aligned run, single granule, claim from an allocated spot
		send_item(pack_item(ACT_MARK_FREE, 64, 128));
		send_item(pack_item(ACT_MARK_FREE, 300, 1));
		send_item(pack_item(ACT_CLAIM_RIGHT, 63, 0));
		send_item(pack_item(ACT_CLAIM_RIGHT, 64, 0));
		send_item(pack_item(ACT_CLAIM_LEFT, 301, 0));
		// ranges that start past the map change nothing
		send_item(pack_item(ACT_MARK_ALLOC, FIELD_MAX, FIELD_MAX));
		send_item(pack_item(ACT_MARK_FREE, FIELD_MAX, 0));
		// a hole in a free range splits it in two
		send_item(pack_item(ACT_MARK_FREE, 1000, 2000));
		send_item(pack_item(ACT_MARK_ALLOC, 1500, 100));
		send_item(pack_item(ACT_CLAIM_LEFT, 1500, 0));
		send_item(pack_item(ACT_CLAIM_RIGHT, 1600, 0));
		send_item(pack_item(ACT_MARK_ALLOC, 0, FIELD_MAX));

		// random part: free ranges followed by claims at their edges
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i == HOLD_AT)
				hold_req = 1'b1;
			if (i == RANDOM_ITEMS - CALM_TAIL)
				idle_on = 1'b0;
			pick = $urandom_range(0, 99);
			if (pick < 30) begin
				pos = ($urandom_range(0, 9) == 0) ? $urandom_range(0, FIELD_MAX)
				                                   : $urandom_range(0, NUM_GRANULES - 1);
				len = pick_length();
				span_lo = pos;
				span_hi = (pos + len > FIELD_MAX) ? FIELD_MAX : pos + len;
				it = pack_item(ACT_MARK_FREE, pos, len);
			end else if (pick < 42) begin
				pos = ($urandom_range(0, 9) == 0) ? $urandom_range(0, FIELD_MAX)
				                                   : $urandom_range(0, NUM_GRANULES - 1);
				it = pack_item(ACT_MARK_ALLOC, pos, pick_length());
			end else if (pick < 71) begin
				// run_length is ignored by claims, fill it with noise
				it = pack_item(ACT_CLAIM_LEFT, pick_boundary(span_hi),
					$urandom_range(0, FIELD_MAX));
			end else begin
				it = pack_item(ACT_CLAIM_RIGHT, pick_boundary(span_lo),
					$urandom_range(0, FIELD_MAX));
			end
			send_item(it);
		end
		item_ch.valid <= 1'b0;

		// let the checker log the last item beat, drain, then wait for a stray beat
		@(posedge clk);
		while (outcomes_owed != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (bad_beats == 0 && outcomes_owed == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

	// watchdog, far beyond the slowest legal run
	initial begin
		#(5_000_000);
		$display("end of test: mismatches");
		$finish;
	end

endmodule
